>>> hw/rtl/dnrs_pkg.sv
package dnrs_pkg;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [2:0] NAV_CYCLE = 3'd0;
    localparam logic [2:0] NAV_LEFT  = 3'd1;
    localparam logic [2:0] NAV_RIGHT = 3'd2;
    localparam logic [2:0] NAV_UP    = 3'd3;
    localparam logic [2:0] NAV_DOWN  = 3'd4;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NO_MOVE   = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic               operation;
        logic        [3:0]  entry_index;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic        [2:0]  direction;
        logic        [3:0]  current_index;
    } t_in_word;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [3:0]  target_index;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } t_out_word;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } t_rect;

    // Geometry of the starting rectangle, held for the whole scan
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [16:0] hq;
        logic signed [16:0] wq;
        logic        [2:0]  dir;
    } t_cur_geom;

    // One evaluated candidate leaving the scan pipeline
    typedef struct packed {
        logic               valid;
        logic               match;
        logic        [31:0] sq_x;
        logic        [31:0] sq_y;
        logic signed [15:0] mx;
        logic signed [15:0] my;
    } t_cand;

    // (a + b) / 2, truncated toward zero
    function automatic logic signed [15:0] mid16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        logic signed [16:0] s;
        logic signed [16:0] s2;
        s  = {a[15], a} + {b[15], b};
        s2 = s + {16'b0, s[16]};
        return s2[16:1];
    endfunction

    // (b - a) / 4, truncated toward zero
    function automatic logic signed [16:0] quarter17(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic signed [16:0] d;
        logic signed [16:0] d2;
        d  = {b[15], b} - {a[15], a};
        d2 = d + (d[16] ? 17'sd3 : 17'sd0);
        return d2 >>> 2;
    endfunction

endpackage

>>> hw/rtl/dnrs_eval.sv
module dnrs_eval #(
    parameter int IW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [IW-1:0]        i_idx,
    input  dnrs_pkg::t_rect      i_rect,
    input  logic [IW-1:0]        i_ci,
    input  dnrs_pkg::t_cur_geom  i_geom,
    output dnrs_pkg::t_cand      o_cand,
    output logic [IW-1:0]        o_idx,
    output logic                 o_busy
);

    // stage b: centers
    logic               r_b_v;
    logic [IW-1:0]      r_b_idx;
    logic signed [15:0] r_b_mx;
    logic signed [15:0] r_b_my;
    // stage c: offsets
    logic               r_c_v;
    logic [IW-1:0]      r_c_idx;
    logic signed [15:0] r_c_mx;
    logic signed [15:0] r_c_my;
    logic signed [16:0] r_c_dx;
    logic signed [16:0] r_c_dy;
    // stage d: cone test and squares
    logic               r_d_v;
    logic               r_d_match;
    logic [IW-1:0]      r_d_idx;
    logic [31:0]        r_d_sqx;
    logic [31:0]        r_d_sqy;
    logic signed [15:0] r_d_mx;
    logic signed [15:0] r_d_my;

    logic [16:0]        c_ax;
    logic [16:0]        c_ay;
    logic [33:0]        c_px;
    logic [33:0]        c_py;
    logic signed [18:0] c_lim_h;
    logic signed [18:0] c_lim_v;
    logic               c_in_h;
    logic               c_in_v;
    logic               c_match;

    always_comb begin
        c_ax    = r_c_dx[16] ? 17'(-r_c_dx) : 17'(r_c_dx);
        c_ay    = r_c_dy[16] ? 17'(-r_c_dy) : 17'(r_c_dy);
        c_px    = c_ax * c_ax;
        c_py    = c_ay * c_ay;
        c_lim_h = $signed({2'b0, 17'((c_ax + 17'd1) >> 1)})
                  + {{2{i_geom.hq[16]}}, i_geom.hq};
        c_lim_v = $signed({2'b0, 17'((c_ay + 17'd1) >> 1)})
                  + {{2{i_geom.wq[16]}}, i_geom.wq};
        c_in_h  = $signed({2'b0, c_ay}) < c_lim_h;
        c_in_v  = $signed({2'b0, c_ax}) < c_lim_v;
        unique case (i_geom.dir)
            dnrs_pkg::NAV_LEFT:  c_match = r_c_dx[16] && c_in_h;
            dnrs_pkg::NAV_RIGHT: c_match = !r_c_dx[16] && (r_c_dx != '0) && c_in_h;
            dnrs_pkg::NAV_UP:    c_match = r_c_dy[16] && c_in_v;
            dnrs_pkg::NAV_DOWN:  c_match = !r_c_dy[16] && (r_c_dy != '0) && c_in_v;
            default:             c_match = 1'b0;
        endcase
        // the starting entry never competes
        if (r_c_idx == i_ci) begin
            c_match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_b_v <= i_valid;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
        r_b_idx   <= i_idx;
        r_b_mx    <= dnrs_pkg::mid16(i_rect.left, i_rect.right);
        r_b_my    <= dnrs_pkg::mid16(i_rect.top, i_rect.bottom);
        r_c_idx   <= r_b_idx;
        r_c_mx    <= r_b_mx;
        r_c_my    <= r_b_my;
        r_c_dx    <= {r_b_mx[15], r_b_mx} - {i_geom.cx[15], i_geom.cx};
        r_c_dy    <= {r_b_my[15], r_b_my} - {i_geom.cy[15], i_geom.cy};
        r_d_idx   <= r_c_idx;
        r_d_mx    <= r_c_mx;
        r_d_my    <= r_c_my;
        r_d_match <= c_match;
        r_d_sqx   <= c_px[31:0];
        r_d_sqy   <= c_py[31:0];
    end

    assign o_cand.valid = r_d_v;
    assign o_cand.match = r_d_match;
    assign o_cand.sq_x  = r_d_sqx;
    assign o_cand.sq_y  = r_d_sqy;
    assign o_cand.mx    = r_d_mx;
    assign o_cand.my    = r_d_my;
    assign o_idx        = r_d_idx;
    assign o_busy       = r_b_v || r_c_v || r_d_v;

endmodule

>>> hw/rtl/directional_nearest_rect_select_unit.sv
// Directional nearest rectangle selector.
// Input channel (i_in_valid / o_in_ready, payload i_in_data) carries load
// words, which write one table entry, and query words, which ask for the
// next entry from a current one in cycle mode or in one of four directions.
// Output channel (o_out_valid / i_out_ready, payload o_out_data) carries one
// result word per query: status, target index and the target's center.
// Loads produce nothing. Queries are handled one at a time; o_in_ready is
// low until the result is placed in the output register. A directional
// query reads the current entry, streams every entry through the
// evaluation pipeline (stages b, c and d) fed by the table's single read
// port, lets it drain, then writes the result. Cycle mode reads the next
// entry, then gives its result; early exits (too few entries, bad index)
// go straight to the result. The next word is taken once the result is in
// the output register. The entry count register is written by i_cfg_we /
// i_cfg_wdata; the user must do so only while idle, the block does not
// enforce it. Reset clears the count, the sequencer and the output valid;
// table contents are undefined until loaded. A stalled receiver holds the
// result word; the block still takes the next word, and a following query
// waits only at its final step until the output register frees up.
module directional_nearest_rect_select_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dnrs_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dnrs_pkg::t_out_word  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRD   = 3'd1;
    localparam logic [2:0] S_TWAIT = 3'd2;
    localparam logic [2:0] S_CRD   = 3'd3;
    localparam logic [2:0] S_CWAIT = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    dnrs_pkg::t_rect     r_mem [MAX_ENTRIES];
    dnrs_pkg::t_rect     r_rd;
    logic                r_rd_v;
    logic [IW-1:0]       r_rd_idx;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [4:0]          r_count;
    logic [CW-1:0]       r_cnt;
    logic [IW-1:0]       r_ci;
    logic [CW-1:0]       r_scan;
    logic [IW-1:0]       r_ti;
    logic [1:0]          r_status;
    logic                r_found;
    logic [32:0]         r_best;
    logic signed [15:0]  r_tx;
    logic signed [15:0]  r_ty;
    dnrs_pkg::t_cur_geom r_geom;
    logic                r_o_v;
    dnrs_pkg::t_out_word r_o_data;

    logic                c_accept;
    logic [CW-1:0]       c_cnt;
    logic [CW-1:0]       c_next;
    logic [IW-1:0]       c_rd_addr;
    logic                c_out_free;
    logic [32:0]         c_dist;
    dnrs_pkg::t_cand     c_cand;
    logic [IW-1:0]       c_cand_idx;
    logic                c_busy;

    assign o_in_ready = (r_state == S_IDLE);
    assign c_accept   = i_in_valid && o_in_ready;
    assign c_out_free = !r_o_v || i_out_ready;
    assign c_cnt      = (32'(r_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(r_count);
    assign c_next     = (CW'(i_in_data.current_index) + CW'(1) == c_cnt)
                        ? '0 : CW'(i_in_data.current_index) + CW'(1);
    assign c_dist     = {1'b0, c_cand.sq_x} + {1'b0, c_cand.sq_y};

    always_comb begin
        unique case (r_state)
            S_TRD:   c_rd_addr = r_ti;
            S_CRD:   c_rd_addr = r_ci;
            default: c_rd_addr = r_scan[IW-1:0];
        endcase
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (c_accept && i_in_data.operation == dnrs_pkg::OP_LOAD
                && 32'(i_in_data.entry_index) < MAX_ENTRIES) begin
            r_mem[IW'(i_in_data.entry_index)] <= '{
                left:   i_in_data.rect_left,
                top:    i_in_data.rect_top,
                right:  i_in_data.rect_right,
                bottom: i_in_data.rect_bottom
            };
        end
        r_rd     <= r_mem[c_rd_addr];
        r_rd_idx <= c_rd_addr;
    end

    dnrs_eval #(
        .IW (IW)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_v),
        .i_idx   (r_rd_idx),
        .i_rect  (r_rd),
        .i_ci    (r_ci),
        .i_geom  (r_geom),
        .o_cand  (c_cand),
        .o_idx   (c_cand_idx),
        .o_busy  (c_busy)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (c_accept && i_in_data.operation == dnrs_pkg::OP_QUERY) begin
                    if (c_cnt <= CW'(1)) begin
                        n_state = S_DONE;
                    end else if (CW'(i_in_data.current_index) >= c_cnt
                            || 32'(i_in_data.current_index) >= MAX_ENTRIES) begin
                        n_state = S_DONE;
                    end else if (i_in_data.direction == dnrs_pkg::NAV_CYCLE) begin
                        n_state = S_TRD;
                    end else begin
                        n_state = S_CRD;
                    end
                end
            end
            S_TRD:   n_state = S_TWAIT;
            S_TWAIT: n_state = S_DONE;
            S_CRD:   n_state = S_CWAIT;
            S_CWAIT: n_state = S_SCAN;
            S_SCAN: begin
                if (r_scan == r_cnt - CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_v && !c_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (c_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_o_v   <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_rd_v <= (r_state == S_SCAN);
            if (r_state == S_DONE && c_out_free) begin
                r_o_v <= 1'b1;
            end else if (i_out_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cnt       <= c_cnt;
                r_ci        <= IW'(i_in_data.current_index);
                r_ti        <= IW'(c_next);
                r_geom.dir  <= i_in_data.direction;
                if (c_cnt <= CW'(1)) begin
                    r_status <= dnrs_pkg::ST_NO_MOVE;
                end else if (CW'(i_in_data.current_index) >= c_cnt
                        || 32'(i_in_data.current_index) >= MAX_ENTRIES) begin
                    r_status <= dnrs_pkg::ST_BAD_INDEX;
                end else begin
                    r_status <= dnrs_pkg::ST_FOUND;
                end
            end
            S_TWAIT: begin
                r_tx <= dnrs_pkg::mid16(r_rd.left, r_rd.right);
                r_ty <= dnrs_pkg::mid16(r_rd.top, r_rd.bottom);
            end
            S_CWAIT: begin
                r_geom.cx <= dnrs_pkg::mid16(r_rd.left, r_rd.right);
                r_geom.cy <= dnrs_pkg::mid16(r_rd.top, r_rd.bottom);
                r_geom.hq <= dnrs_pkg::quarter17(r_rd.top, r_rd.bottom);
                r_geom.wq <= dnrs_pkg::quarter17(r_rd.left, r_rd.right);
                r_scan    <= '0;
                r_found   <= 1'b0;
            end
            S_SCAN: begin
                r_scan <= r_scan + CW'(1);
            end
            S_DRAIN: begin
                if (!r_rd_v && !c_busy) begin
                    r_status <= r_found ? dnrs_pkg::ST_FOUND : dnrs_pkg::ST_NO_MOVE;
                end
            end
            S_DONE: begin
                if (c_out_free) begin
                    r_o_data.status <= r_status;
                    if (r_status == dnrs_pkg::ST_FOUND) begin
                        r_o_data.target_index <= 4'(r_ti);
                        r_o_data.target_x     <= r_tx;
                        r_o_data.target_y     <= r_ty;
                    end else begin
                        r_o_data.target_index <= '0;
                        r_o_data.target_x     <= '0;
                        r_o_data.target_y     <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
        // keep the nearest match; strict less keeps the lower index on ties
        if (c_cand.valid && c_cand.match && (!r_found || c_dist < r_best)) begin
            r_found <= 1'b1;
            r_best  <= c_dist;
            r_ti    <= c_cand_idx;
            r_tx    <= c_cand.mx;
            r_ty    <= c_cand.my;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o_data;

endmodule

>>> test/directional_nearest_rect_select_unit_tb.sv
`timescale 1ns / 1ps

module directional_nearest_rect_select_unit_tb;

    localparam int MAX_ENTRIES = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    dnrs_pkg::t_in_word   i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    dnrs_pkg::t_out_word  o_out_data;
    logic                 i_cfg_we;
    logic [4:0]           i_cfg_wdata;

    directional_nearest_rect_select_unit #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Mirror of the block's table and entry count
    dnrs_pkg::t_rect      rect_mirror [MAX_ENTRIES];
    logic [4:0]           count_mirror;

    dnrs_pkg::t_in_word   pending_words [$];
    dnrs_pkg::t_out_word  nav_results_due [$];
    int          words_sent;
    int          words_taken;
    int          mismatch_count;
    int          cycle_count;
    bit          calm_phase;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int center(logic signed [15:0] a, logic signed [15:0] b);
        return (int'(a) + int'(b)) / 2;
    endfunction

    function automatic int magn(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic dnrs_pkg::t_out_word predict_nav_target(dnrs_pkg::t_in_word w);
        dnrs_pkg::t_out_word res;
        dnrs_pkg::t_rect     cur;
        dnrs_pkg::t_rect     cand;
        int        eff, ci, cx, cy, hq, wq, dx, dy, i, pick;
        longint    sq_dist, best;
        bit        hit, found;
        res = '0;
        res.status = dnrs_pkg::ST_NO_MOVE;
        eff = (count_mirror > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_mirror);
        ci = int'(w.current_index);
        found = 1'b0;
        best = 0;
        pick = 0;
        if (eff <= 1) begin
            res.status = dnrs_pkg::ST_NO_MOVE;
        end else if (ci >= eff) begin
            res.status = dnrs_pkg::ST_BAD_INDEX;
        end else if (w.direction == dnrs_pkg::NAV_CYCLE) begin
            res.status = dnrs_pkg::ST_FOUND;
            pick = (ci + 1) % eff;
        end else begin
            cur = rect_mirror[ci];
            cx = center(cur.left, cur.right);
            cy = center(cur.top, cur.bottom);
            hq = (int'(cur.bottom) - int'(cur.top)) / 4;
            wq = (int'(cur.right) - int'(cur.left)) / 4;
            for (i = 0; i < eff; i++) begin
                if (i != ci) begin
                    cand = rect_mirror[i];
                    dx = center(cand.left, cand.right) - cx;
                    dy = center(cand.top, cand.bottom) - cy;
                    case (w.direction)
                        dnrs_pkg::NAV_LEFT:
                            hit = dx < 0 && magn(dy) < (magn(dx) + 1) / 2 + hq;
                        dnrs_pkg::NAV_RIGHT:
                            hit = dx > 0 && magn(dy) < (magn(dx) + 1) / 2 + hq;
                        dnrs_pkg::NAV_UP:
                            hit = dy < 0 && magn(dx) < (magn(dy) + 1) / 2 + wq;
                        dnrs_pkg::NAV_DOWN:
                            hit = dy > 0 && magn(dx) < (magn(dy) + 1) / 2 + wq;
                        default:
                            hit = 1'b0;
                    endcase
                    if (hit) begin
                        sq_dist = longint'(dx) * dx + longint'(dy) * dy;
                        // strict compare keeps the lower index on a tie
                        if (!found || sq_dist < best) begin
                            found = 1'b1;
                            best = sq_dist;
                            pick = i;
                        end
                    end
                end
            end
            res.status = found ? dnrs_pkg::ST_FOUND : dnrs_pkg::ST_NO_MOVE;
        end
        if (res.status == dnrs_pkg::ST_FOUND) begin
            res.target_index = 4'(pick);
            res.target_x = 16'(center(rect_mirror[pick].left, rect_mirror[pick].right));
            res.target_y = 16'(center(rect_mirror[pick].top, rect_mirror[pick].bottom));
        end
        return res;
    endfunction

    function automatic dnrs_pkg::t_in_word noise_word();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[75:0];
    endfunction

    function automatic dnrs_pkg::t_in_word load_word(int idx, int l, int t, int r, int b);
        dnrs_pkg::t_in_word w;
        w = noise_word();
        w.operation = dnrs_pkg::OP_LOAD;
        w.entry_index = 4'(idx);
        w.rect_left = 16'(l);
        w.rect_top = 16'(t);
        w.rect_right = 16'(r);
        w.rect_bottom = 16'(b);
        return w;
    endfunction

    function automatic dnrs_pkg::t_in_word query_word(logic [2:0] dir, int ci);
        dnrs_pkg::t_in_word w;
        w = noise_word();
        w.operation = dnrs_pkg::OP_QUERY;
        w.direction = dir;
        w.current_index = 4'(ci);
        return w;
    endfunction

    function automatic dnrs_pkg::t_in_word random_load(int idx);
        dnrs_pkg::t_in_word w;
        int cx, cy, hw, hh, pick;
        w = noise_word();
        w.operation = dnrs_pkg::OP_LOAD;
        w.entry_index = 4'(idx);
        pick = $urandom_range(99);
        if (pick < 55) begin
            // compact layout so the cones see each other
            cx = $urandom_range(2000) - 1000;
            cy = $urandom_range(2000) - 1000;
            hw = $urandom_range(300);
            hh = $urandom_range(300);
            if (pick < 8) begin
                hw = -hw;
                hh = -hh;
            end
            w = load_word(idx, cx - hw, cy - hh, cx + hw, cy + hh);
        end
        return w;
    endfunction

    function automatic dnrs_pkg::t_in_word random_query(int eff);
        logic [2:0] dir;
        int ci, pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            dir = 3'($urandom_range(dnrs_pkg::NAV_LEFT, dnrs_pkg::NAV_DOWN));
        end else if (pick < 92) begin
            dir = dnrs_pkg::NAV_CYCLE;
        end else begin
            dir = 3'($urandom_range(5, 7));
        end
        if (eff >= 1 && $urandom_range(99) < 90) begin
            ci = $urandom_range(eff - 1);
        end else begin
            ci = $urandom_range(15);
        end
        return query_word(dir, ci);
    endfunction

    task automatic settle();
        while (pending_words.size() != 0 || words_sent != words_taken
               || nav_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [4:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        count_mirror = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 5'($urandom);
    endtask

    // Driver: hold a word until taken, then advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || words_sent == words_taken)) begin
            if (pending_words.size() != 0 && (calm_phase || $urandom_range(99) >= 28)) begin
                i_in_data <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                words_sent <= words_sent + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm_phase || ($urandom_range(99) >= 28);
    end

    // Monitor: check results, then update the mirror with taken words
    always @(posedge i_clk) begin : watch
        dnrs_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (nav_results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, got status %0d index %0d x %0d y %0d",
                             $time, o_out_data.status, o_out_data.target_index,
                             o_out_data.target_x, o_out_data.target_y);
                end else begin
                    want = nav_results_due.pop_front();
                    if (want.status !== o_out_data.status
                        || want.target_index !== o_out_data.target_index
                        || want.target_x !== o_out_data.target_x
                        || want.target_y !== o_out_data.target_y) begin
                        mismatch_count++;
                        $write("%0t: expected status %0d index %0d x %0d y %0d,",
                               $time, want.status, want.target_index, want.target_x,
                               want.target_y);
                        $display(" got status %0d index %0d x %0d y %0d",
                                 o_out_data.status, o_out_data.target_index,
                                 o_out_data.target_x, o_out_data.target_y);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                words_taken <= words_taken + 1;
                if (i_in_data.operation == dnrs_pkg::OP_LOAD) begin
                    rect_mirror[i_in_data.entry_index] = {i_in_data.rect_left,
                        i_in_data.rect_top, i_in_data.rect_right, i_in_data.rect_bottom};
                end else begin
                    nav_results_due.push_back(predict_nav_target(i_in_data));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        logic [4:0] phase_counts [8];
        int ph, n, eff, span, k;
        phase_counts = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd9, 5'd0, 5'd17, 5'd0};
        phase_counts[7] = 5'($urandom_range(2, 31));
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        count_mirror = '0;
        words_sent = 0;
        words_taken = 0;
        mismatch_count = 0;
        cycle_count = 0;
        calm_phase = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table after reset: no move
        pending_words.push_back(query_word(dnrs_pkg::NAV_CYCLE, 0));
        // Full-range rectangle, both extreme corners, and a small grid
        pending_words.push_back(load_word(0, -32768, -32768, 32767, 32767));
        pending_words.push_back(load_word(14, -32768, -32768, -32768, -32768));
        pending_words.push_back(load_word(15, 32767, 32767, 32767, 32767));
        for (k = 1; k < 14; k++) begin
            pending_words.push_back(load_word(k, (k % 4) * 100 - 150, (k / 4) * 100 - 150,
                                              (k % 4) * 100 - 110, (k / 4) * 100 - 110));
        end
        settle();
        write_count(5'd16);
        pending_words.push_back(query_word(dnrs_pkg::NAV_CYCLE, 15));
        pending_words.push_back(query_word(dnrs_pkg::NAV_LEFT, 6));
        pending_words.push_back(query_word(dnrs_pkg::NAV_RIGHT, 6));
        pending_words.push_back(query_word(dnrs_pkg::NAV_UP, 6));
        pending_words.push_back(query_word(dnrs_pkg::NAV_DOWN, 6));
        pending_words.push_back(query_word(dnrs_pkg::NAV_LEFT, 0));
        pending_words.push_back(query_word(dnrs_pkg::NAV_DOWN, 14));
        pending_words.push_back(query_word(dnrs_pkg::NAV_UP, 15));
        pending_words.push_back(query_word(3'd7, 3));
        settle();

        for (ph = 0; ph < 8; ph++) begin
            write_count(phase_counts[ph]);
            calm_phase = (ph == 2);
            eff = (phase_counts[ph] > MAX_ENTRIES) ? MAX_ENTRIES : int'(phase_counts[ph]);
            span = (eff <= 1) ? 40 : 190;
            for (n = 0; n < span; n++) begin
                if ($urandom_range(99) < 30) begin
                    pending_words.push_back(random_load($urandom_range(15)));
                end else begin
                    pending_words.push_back(random_query(eff));
                end
            end
            settle();
        end
        calm_phase = 1'b0;

        if (mismatch_count == 0 && nav_results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
